>>> hdl/mmam_pkg.sv
// Shared constants, types and the result mask function for the
// multiply-accumulate block. No dependencies.
`default_nettype none

package mmam_pkg;

  localparam int ROWS    = 8;
  localparam int LANES   = 8;
  localparam int LANE_W  = 16;
  localparam int ROW_W   = 3;
  localparam int MODB_W  = 5;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WORD_W  = LANES * LANE_W;
  localparam logic [MODB_W-1:0] MODB_RESET = MODB_W'(15);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAC  = 1'b1;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t [LANES-1:0] lanes_t;

  // all ones below bit b, saturating at the full lane width
  function automatic lane_t lane_mask(input logic [MODB_W-1:0] b);
    logic [LANE_W:0] one;
    one = (LANE_W+1)'(1) << b;
    if (b >= MODB_W'(LANE_W)) begin
      lane_mask = '1;
    end else begin
      lane_mask = one[LANE_W-1:0] - LANE_W'(1);
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/matrix_mul_add_mod_q_sb_plus_e.sv
// Top level: accumulator row memory with read-modify-write pipeline and output register.
// Depends on mmam_pkg.
`default_nettype none

// Accumulates out = s*b + e modulo 2^modulus_bits one 8-lane row per item. A load item
// (tuser 0) writes the lanes as the row's bias; a multiply-accumulate item (tuser 1) adds
// scalar*lane to each accumulator of the row, modulo 2^16. Every item returns the updated
// row, masked to modulus_bits. One item is accepted per cycle unless the output stalls;
// the row memory is read into stage one, then the eight multiply-adds and the write-back
// are done as the item moves to the output register. A row written in the cycle that the
// next item reads it is bypassed, so back-to-back items on the same row are correct. Reset
// clears the accumulators at once through one valid bit per row; there is no clearing pass.
module matrix_mul_add_mod_q_sb_plus_e
  import mmam_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // row [2:0], scalar [18:3], vector_0..vector_7 [146:19] (16 bits each), zero fill
  input  wire logic [151:0] in_tdata,
  // operation [0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // row_out [2:0], result_0..result_7 [130:3] (16 bits each), zero fill
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [MODB_W-1:0] cfg_wr_data
);

  logic [WORD_W-1:0]  mem [ROWS];
  logic [ROWS-1:0]    rowv_r;
  logic [MODB_W-1:0]  modb_r;

  logic               s1_valid_r;
  logic               s1_op_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic               s1_inr_r;
  lane_t              s1_scalar_r;
  lanes_t             s1_lanes_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_valid_r;
  logic               byp_r;
  lanes_t             byp_data_r;

  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  lanes_t             out_res_r;

  logic               in_fire, s1_fire, out_free;
  logic [ROW_W-1:0]   in_row;
  logic               in_inr;
  lanes_t             in_lanes, acc_old, acc_new, res_nxt;
  lane_t              mask;
  logic [2*LANE_W-1:0] prod [LANES];

  assign in_row = in_tdata[ROW_W-1:0];
  assign in_inr = (5'(in_row) < 5'(ROWS));
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      in_lanes[k] = in_tdata[ROW_W + LANE_W + k*LANE_W +: LANE_W];
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign mask      = lane_mask(modb_r);

  // modify: pick the current row value, bypassing the write made when this item was accepted
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (byp_r) begin
        acc_old[k] = byp_data_r[k];
      end else if (rd_valid_r) begin
        acc_old[k] = rd_data_r[k*LANE_W +: LANE_W];
      end else begin
        acc_old[k] = '0;
      end
      prod[k] = s1_scalar_r * s1_lanes_r[k];
      if (s1_op_r == OP_MAC) begin
        acc_new[k] = acc_old[k] + prod[k][LANE_W-1:0];
      end else begin
        acc_new[k] = s1_lanes_r[k];
      end
      res_nxt[k] = s1_inr_r ? (acc_new[k] & mask) : '0;
    end
  end

  // row memory: registered read on accept, write-back when the item leaves stage one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[ROW_AW'(in_row)];
    end
    if (s1_fire && s1_inr_r) begin
      mem[ROW_AW'(s1_row_r)] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r      <= '0;
      modb_r      <= MODB_RESET;
      s1_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modb_r <= cfg_wr_data;
      end
      if (s1_fire && s1_inr_r) begin
        rowv_r[ROW_AW'(s1_row_r)] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_fire && s1_inr_r && (s1_row_r == in_row);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        byp_r      <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_tuser;
      s1_row_r    <= in_row;
      s1_inr_r    <= in_inr;
      s1_scalar_r <= in_tdata[ROW_W +: LANE_W];
      s1_lanes_r  <= in_lanes;
      rd_valid_r  <= rowv_r[ROW_AW'(in_row)];
      byp_data_r  <= acc_new;
    end
    if (s1_fire) begin
      out_row_r <= s1_row_r;
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r, out_row_r};

  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("stage one item did not reach the output register");

  a_bypass_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_fire && s1_inr_r && (s1_row_r == in_row)) |=> byp_r)
    else $error("same-row write not bypassed");

  a_bypass_busy: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> s1_valid_r)
    else $error("bypass flagged with stage one empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r && (rowv_r == '0)))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> verif/matrix_mul_add_mod_q_sb_plus_e_tb.sv
// Self-checking testbench for the multiply-accumulate row block: drives load and
// multiply-accumulate items, predicts each returned row and checks it lane by lane.
// Depends on mmam_pkg and matrix_mul_add_mod_q_sb_plus_e.
`timescale 1ns / 1ps

module matrix_mul_add_mod_q_sb_plus_e_tb;
  import mmam_pkg::*;

  typedef struct packed {
    lanes_t            vals;
    logic [ROW_W-1:0]  row;
  } row_result_t;

  // Predicts each returned row from its own copy of the accumulators and the width
  class mac_scoreboard;
    lane_t             acc_rows [ROWS][LANES];
    logic [MODB_W-1:0] width_bits;
    row_result_t       expected_rows [$];
    int                errors;

    function new();
      foreach (acc_rows[r, k]) acc_rows[r][k] = '0;
      width_bits = MODB_RESET;
      errors = 0;
    endfunction

    function void set_width(logic [MODB_W-1:0] b);
      width_bits = b;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    function lane_t result_mask();
      int unsigned m;
      if (width_bits >= MODB_W'(LANE_W)) return '1;
      m = (32'd1 << width_bits) - 1;
      return m[LANE_W-1:0];
    endfunction

    // update the row and queue the masked copy that the block should return
    function void accept_item(logic op, logic [151:0] d);
      row_result_t  res;
      int unsigned  r;
      lane_t        scalar, lane;
      logic [31:0]  prod;
      r = d[ROW_W-1:0];
      scalar = d[18:3];
      res.row = d[ROW_W-1:0];
      for (int k = 0; k < LANES; k++) begin
        lane = d[19 + LANE_W*k +: LANE_W];
        if (r >= ROWS) begin
          res.vals[k] = '0;
        end else begin
          if (op == OP_LOAD) begin
            acc_rows[r][k] = lane;
          end else begin
            prod = scalar * lane;
            acc_rows[r][k] = acc_rows[r][k] + prod[LANE_W-1:0];
          end
          res.vals[k] = acc_rows[r][k] & result_mask();
        end
      end
      expected_rows.push_back(res);
    endfunction

    function void check_row(logic [135:0] d);
      row_result_t want;
      lane_t       got;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row item, expected none, got %h", $time, d);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (d[ROW_W-1:0] !== want.row) begin
        $display("%0t: row_out expected %0d got %0d", $time, want.row, d[ROW_W-1:0]);
        errors++;
      end
      for (int k = 0; k < LANES; k++) begin
        got = d[ROW_W + LANE_W*k +: LANE_W];
        if (got !== want.vals[k]) begin
          $display("%0t: row %0d result_%0d expected %h got %h",
                   $time, want.row, k, want.vals[k], got);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [151:0]      in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [135:0]      out_tdata;
  logic              cfg_wr_en;
  logic [MODB_W-1:0] cfg_wr_data;

  mac_scoreboard sb;
  int            tx_idle_pct;
  int            rx_stall_pct;
  int            rx_hold;

  matrix_mul_add_mod_q_sb_plus_e dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("matrix_mul_add_mod_q_sb_plus_e_tb NOT OK");
    $finish;
  end

  // receiver: a long hold-off counts down here, otherwise stall at random
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.accept_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata);
  end

  function automatic lane_t rand_word();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return '1;
    if (p < 24) return lane_t'($urandom_range(3));
    return lane_t'($urandom_range(65535));
  endfunction

  function automatic lanes_t rand_lanes();
    lanes_t v;
    for (int k = 0; k < LANES; k++) v[k] = rand_word();
    return v;
  endfunction

  function automatic lanes_t fill_lanes(lane_t w);
    lanes_t v;
    for (int k = 0; k < LANES; k++) v[k] = w;
    return v;
  endfunction

  task automatic send_item(logic op, logic [ROW_W-1:0] row, lane_t scalar, lanes_t v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, v, scalar, row};
    do @(posedge clk); while (!in_tready);
  endtask

  // wait for a clock edge first so that the item accepted at the last edge is counted
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_width(logic [MODB_W-1:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_width(b);
  endtask

  initial begin
    logic [MODB_W-1:0] widths [10];
    logic [ROW_W-1:0]  r;
    lanes_t            v;
    int                n;
    int                m;
    bit                paused;

    sb = new();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= OP_LOAD;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at the reset width: accumulate onto cleared rows, load every row,
    // wrap at 2^16, zero and unit scalars, and back-to-back items on one row
    for (int k = 0; k < LANES; k++) v[k] = lane_t'(k + 1);
    send_item(OP_MAC, 3'd0, 16'd3, v);
    send_item(OP_MAC, 3'd6, 16'hFFFF, fill_lanes('1));
    send_item(OP_LOAD, 3'd0, 16'h0000, fill_lanes('1));
    send_item(OP_LOAD, 3'd7, 16'hFFFF, fill_lanes('0));
    for (int k = 1; k < ROWS - 1; k++) send_item(OP_LOAD, ROW_W'(k), rand_word(), rand_lanes());
    send_item(OP_MAC, 3'd0, 16'hFFFF, fill_lanes('1));
    send_item(OP_MAC, 3'd0, 16'hFFFF, fill_lanes('1));
    send_item(OP_MAC, 3'd7, 16'h0000, fill_lanes('1));
    send_item(OP_MAC, 3'd5, 16'h0001, fill_lanes('1));
    for (int k = 0; k < 3; k++) send_item(OP_MAC, 3'd3, rand_word(), rand_lanes());
    for (int k = 0; k < LANES; k++) v[k] = k[0] ? 16'h5555 : 16'hAAAA;
    send_item(OP_LOAD, 3'd2, 16'h8000, v);
    send_item(OP_MAC, 3'd2, 16'h8000, fill_lanes(16'h0001));
    send_item(OP_LOAD, 3'd7, 16'h0000, fill_lanes(16'h8000));

    widths = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd8, 5'd17, 5'd15,
               MODB_W'($urandom_range(31)), 5'd14, 5'd5};
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      repeat (4) @(posedge clk);
      write_width(widths[phase]);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      // hold the receiver off so that the block backs up and stalls its input
      if (phase == 0) rx_hold = 300;
      n = 0;
      paused = 0;
      while (n < 113) begin
        if (phase == 5 && !paused && n >= 56) begin
          drain();
          paused = 1;
        end
        r = ROW_W'($urandom_range(ROWS - 1));
        if ($urandom_range(99) < 70) begin
          // one inner-product pass: a bias row most of the time, then the steps over j
          if ($urandom_range(99) < 85) begin
            send_item(OP_LOAD, r, rand_word(), rand_lanes());
            n++;
          end
          m = $urandom_range(8, 1);
          for (int j = 0; j < m; j++) send_item(OP_MAC, r, rand_word(), rand_lanes());
          n += m;
        end else begin
          send_item($urandom_range(1) ? OP_MAC : OP_LOAD, r, rand_word(), rand_lanes());
          n++;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("matrix_mul_add_mod_q_sb_plus_e_tb OK");
    end else begin
      $display("matrix_mul_add_mod_q_sb_plus_e_tb NOT OK");
    end
    $finish;
  end

endmodule
